/* design/pcs_pkg.sv */
// ----------------------------------------------------------------------------
// pcs_pkg
// Shared types and constants of the co-rated Pearson similarity block.
// ----------------------------------------------------------------------------
`default_nettype none

package pcs_pkg;

    localparam int MEAN_W  = 19;
    localparam int RATE_W  = 3;
    localparam int SIM_W   = 16;
    localparam int CNT_W   = 11;
    localparam int ST_W    = 2;
    localparam int CROSS_W = 48;
    localparam int SQ_W    = 47;
    localparam int DEV_W   = 20;
    localparam int PROD_W  = 40;
    localparam int SQP_W   = 39;
    localparam int QDEPTH  = 2;
    localparam int QCNT_W  = 2;

    localparam logic [CNT_W-1:0]  COUNT_CAP  = 11'd1024;
    localparam logic [MEAN_W-1:0] MEAN_RESET = 19'd196608;

    localparam logic [ST_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [ST_W-1:0] STATUS_FEW  = 2'd1;
    localparam logic [ST_W-1:0] STATUS_FLAT = 2'd2;

    typedef struct packed {
        logic [RATE_W-1:0] rating_first;
        logic [RATE_W-1:0] rating_second;
        logic              last_item;
    } item_t;

    typedef struct packed {
        logic signed [SIM_W-1:0] similarity;
        logic [CNT_W-1:0]        corated_count;
        logic [ST_W-1:0]         status;
    } result_t;

    typedef struct packed {
        logic signed [CROSS_W-1:0] cross_sum;
        logic [SQ_W-1:0]           first_square_sum;
        logic [SQ_W-1:0]           second_square_sum;
        logic [CNT_W-1:0]          pair_count;
    } sums_t;

endpackage

`default_nettype wire

/* design/pcs_front.sv */
// ----------------------------------------------------------------------------
// pcs_front
// Deviation products and saturating accumulation, one item per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pcs_front (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     accept,
    input  wire pcs_pkg::item_t           item,
    input  wire logic [pcs_pkg::MEAN_W-1:0] mean_first,
    input  wire logic [pcs_pkg::MEAN_W-1:0] mean_second,
    input  wire logic [pcs_pkg::QCNT_W-1:0] q_count,
    output logic                          busy_last,
    output logic                          q_push,
    output pcs_pkg::sums_t                q_data
);

    logic                              s1_valid_reg;
    logic                              s1_last_reg;
    logic                              s1_rated_reg;
    logic signed [pcs_pkg::PROD_W-1:0] s1_cross_reg;
    logic [pcs_pkg::SQP_W-1:0]         s1_sq1_reg;
    logic [pcs_pkg::SQP_W-1:0]         s1_sq2_reg;

    logic signed [pcs_pkg::DEV_W-1:0]  du;
    logic signed [pcs_pkg::DEV_W-1:0]  dv;
    logic signed [pcs_pkg::PROD_W-1:0] p_uv;
    logic signed [pcs_pkg::PROD_W-1:0] p_uu;
    logic signed [pcs_pkg::PROD_W-1:0] p_vv;

    pcs_pkg::sums_t acc_reg;
    pcs_pkg::sums_t acc_upd;
    logic [pcs_pkg::CROSS_W:0] cross_ext;
    logic [pcs_pkg::SQ_W:0]    sq1_ext;
    logic [pcs_pkg::SQ_W:0]    sq2_ext;

    always_comb
    begin
        du = $signed({1'b0, item.rating_first, 16'b0}) - $signed({1'b0, mean_first});
        dv = $signed({1'b0, item.rating_second, 16'b0}) - $signed({1'b0, mean_second});
        p_uv = du * dv;
        p_uu = du * du;
        p_vv = dv * dv;
    end

    // stage one: register the three products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s1_last_reg  <= accept & item.last_item;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_rated_reg <= (item.rating_first != '0) && (item.rating_second != '0);
            s1_cross_reg <= p_uv;
            s1_sq1_reg   <= p_uu[pcs_pkg::SQP_W-1:0];
            s1_sq2_reg   <= p_vv[pcs_pkg::SQP_W-1:0];
        end
    end

    // stage two: saturating sums
    always_comb
    begin
        cross_ext = {acc_reg.cross_sum[pcs_pkg::CROSS_W-1], acc_reg.cross_sum}
                  + {{(pcs_pkg::CROSS_W+1-pcs_pkg::PROD_W){s1_cross_reg[pcs_pkg::PROD_W-1]}},
                     s1_cross_reg};
        sq1_ext = {1'b0, acc_reg.first_square_sum}
                + {{(pcs_pkg::SQ_W+1-pcs_pkg::SQP_W){1'b0}}, s1_sq1_reg};
        sq2_ext = {1'b0, acc_reg.second_square_sum}
                + {{(pcs_pkg::SQ_W+1-pcs_pkg::SQP_W){1'b0}}, s1_sq2_reg};
        acc_upd = acc_reg;
        if (s1_rated_reg)
        begin
            if (cross_ext[pcs_pkg::CROSS_W] != cross_ext[pcs_pkg::CROSS_W-1])
                acc_upd.cross_sum = cross_ext[pcs_pkg::CROSS_W] ?
                    {1'b1, {(pcs_pkg::CROSS_W-1){1'b0}}} :
                    {1'b0, {(pcs_pkg::CROSS_W-1){1'b1}}};
            else
                acc_upd.cross_sum = cross_ext[pcs_pkg::CROSS_W-1:0];
            acc_upd.first_square_sum = sq1_ext[pcs_pkg::SQ_W] ? '1 :
                                       sq1_ext[pcs_pkg::SQ_W-1:0];
            acc_upd.second_square_sum = sq2_ext[pcs_pkg::SQ_W] ? '1 :
                                        sq2_ext[pcs_pkg::SQ_W-1:0];
            if (acc_reg.pair_count < pcs_pkg::COUNT_CAP)
                acc_upd.pair_count = acc_reg.pair_count + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_reg <= '0;
        else if (s1_valid_reg)
            acc_reg <= s1_last_reg ? '0 : acc_upd;
    end

    assign q_push    = s1_valid_reg & s1_last_reg;
    assign q_data    = acc_upd;
    assign busy_last = s1_valid_reg & s1_last_reg;

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> q_count < pcs_pkg::QCNT_W'(pcs_pkg::QDEPTH))
        else $error("front pushed into a full queue");

endmodule

`default_nettype wire

/* design/pcs_queue.sv */
// ----------------------------------------------------------------------------
// pcs_queue
// Two-entry queue of finished pair sums between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module pcs_queue (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    input  wire pcs_pkg::sums_t             wdata,
    input  wire logic                       pop,
    output pcs_pkg::sums_t                  rdata,
    output logic                            not_empty,
    output logic [pcs_pkg::QCNT_W-1:0]      count
);

    pcs_pkg::sums_t                  mem_reg [pcs_pkg::QDEPTH];
    logic                            wr_ptr_reg;
    logic                            rd_ptr_reg;
    logic [pcs_pkg::QCNT_W-1:0]      count_reg;
    logic                            do_pop;

    function automatic logic [pcs_pkg::QCNT_W-1:0] QCNT_ONE(input logic b);
        QCNT_ONE = {{(pcs_pkg::QCNT_W-1){1'b0}}, b};
    endfunction

    assign do_pop    = pop & (count_reg != '0);
    assign rdata     = mem_reg[rd_ptr_reg];
    assign not_empty = count_reg != '0;
    assign count     = count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + QCNT_ONE(push) - QCNT_ONE(do_pop);
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= pcs_pkg::QCNT_W'(pcs_pkg::QDEPTH))
        else $error("queue count beyond depth");

endmodule

`default_nettype wire

/* design/pcs_back.sv */
// ----------------------------------------------------------------------------
// pcs_back
// Classifies one pair's sums and searches the clamped Q1.14 correlation.
// ----------------------------------------------------------------------------
`default_nettype none

module pcs_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              rec_valid,
    input  wire pcs_pkg::sums_t    rec,
    output logic                   rec_pop,
    output pcs_pkg::result_t       result,
    output logic                   res_valid,
    input  wire logic              res_pop
);

    localparam int W   = 125;
    localparam int BW  = 48;
    localparam int MW  = 15;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MAB  = 3'd1;
    localparam logic [2:0] S_MNN  = 3'd2;
    localparam logic [2:0] S_ODD  = 3'd3;
    localparam logic [2:0] S_MT   = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic [W-1:0]       ma_reg, ma_next;
    logic [BW-1:0]      mb_reg, mb_next;
    logic [W-1:0]       macc_reg, macc_next;
    logic [W-1:0]       prod_reg, prod_next;
    logic [W-1:0]       num2_reg, num2_next;
    logic [BW-1:0]      mag_reg, mag_next;
    logic               neg_reg, neg_next;
    logic [MW-1:0]      lo_reg, lo_next;
    logic [MW-1:0]      hi_reg, hi_next;
    logic [MW-1:0]      mid_reg, mid_next;
    logic [pcs_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [pcs_pkg::ST_W-1:0]  st_reg, st_next;
    logic               res_valid_reg, res_valid_next;
    pcs_pkg::result_t   res_reg, res_next;

    logic [MW:0]        mid_sum;
    logic [MW-1:0]      mid_w;
    logic [MW-1:0]      odd_w;
    logic [2*MW-1:0]    odd2_w;
    logic [BW-1:0]      cross_abs;
    logic signed [pcs_pkg::SIM_W-1:0] sim_w;

    always_comb
    begin
        mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg} + 1'b1;
        mid_w   = mid_sum[MW:1];
        odd_w   = {mid_w[MW-2:0], 1'b0} - 1'b1;
        odd2_w  = odd_w * odd_w;
        cross_abs = rec.cross_sum[pcs_pkg::CROSS_W-1] ?
                    BW'(-rec.cross_sum) : BW'(rec.cross_sum);
        sim_w = neg_reg ? -$signed({1'b0, lo_reg}) : $signed({1'b0, lo_reg});
    end

    always_comb
    begin
        state_next     = state_reg;
        ma_next        = ma_reg;
        mb_next        = mb_reg;
        macc_next      = macc_reg;
        prod_next      = prod_reg;
        num2_next      = num2_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        cnt_next       = cnt_reg;
        st_next        = st_reg;
        res_valid_next = res_valid_reg & ~res_pop;
        res_next       = res_reg;
        rec_pop        = 1'b0;

        // shift-add step, shared by all products
        if (mb_reg != '0)
        begin
            if (mb_reg[0])
                macc_next = macc_reg + ma_reg;
            ma_next = {ma_reg[W-2:0], 1'b0};
            mb_next = {1'b0, mb_reg[BW-1:1]};
        end

        case (state_reg)
            S_IDLE:
            begin
                if (rec_valid)
                begin
                    rec_pop  = 1'b1;
                    cnt_next = rec.pair_count;
                    lo_next  = '0;
                    neg_next = 1'b0;
                    if (rec.pair_count < 2)
                    begin
                        st_next    = pcs_pkg::STATUS_FEW;
                        state_next = S_DONE;
                    end
                    else if (rec.first_square_sum == '0 || rec.second_square_sum == '0)
                    begin
                        st_next    = pcs_pkg::STATUS_FLAT;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        st_next    = pcs_pkg::STATUS_OK;
                        neg_next   = rec.cross_sum[pcs_pkg::CROSS_W-1];
                        mag_next   = cross_abs;
                        ma_next    = W'(rec.first_square_sum);
                        mb_next    = BW'(rec.second_square_sum);
                        macc_next  = '0;
                        state_next = S_MAB;
                    end
                end
            end
            S_MAB:
            begin
                if (mb_reg == '0)
                begin
                    prod_next  = macc_reg;
                    ma_next    = W'(mag_reg);
                    mb_next    = mag_reg;
                    macc_next  = '0;
                    state_next = S_MNN;
                end
            end
            S_MNN:
            begin
                if (mb_reg == '0)
                begin
                    num2_next  = {macc_reg[W-31:0], 30'b0};
                    lo_next    = '0;
                    hi_next    = MW'(16384);
                    state_next = S_ODD;
                end
            end
            S_ODD:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next   = mid_w;
                    ma_next    = prod_reg;
                    mb_next    = BW'(odd2_w);
                    macc_next  = '0;
                    state_next = S_MT;
                end
                else
                    state_next = S_DONE;
            end
            S_MT:
            begin
                if (mb_reg == '0)
                begin
                    if (macc_reg <= num2_reg)
                        lo_next = mid_reg;
                    else
                        hi_next = mid_reg - 1'b1;
                    state_next = S_ODD;
                end
            end
            S_DONE:
            begin
                if (!res_valid_reg || res_pop)
                begin
                    res_valid_next         = 1'b1;
                    res_next.similarity    = sim_w;
                    res_next.corated_count = cnt_reg;
                    res_next.status        = st_reg;
                    state_next             = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
            mb_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            mb_reg        <= mb_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ma_reg   <= ma_next;
        macc_reg <= macc_next;
        prod_reg <= prod_next;
        num2_reg <= num2_next;
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        mid_reg  <= mid_next;
        cnt_reg  <= cnt_next;
        st_reg   <= st_next;
        res_reg  <= res_next;
    end

    assign result    = res_reg;
    assign res_valid = res_valid_reg;

    a_ok_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.status == pcs_pkg::STATUS_OK |->
        res_reg.corated_count >= 2)
        else $error("computed result with too few co-rated items");

    a_zero_sim: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.status != pcs_pkg::STATUS_OK |->
        res_reg.similarity == '0)
        else $error("special-case result carries nonzero similarity");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_pop |=> res_valid_reg && $stable(res_reg))
        else $error("waiting result changed");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        rec_pop |-> state_reg == S_IDLE && rec_valid)
        else $error("record taken outside idle");

endmodule

`default_nettype wire

/* design/pearson_corated_similarity.sv */
// ----------------------------------------------------------------------------
// pearson_corated_similarity
// Streamed Pearson similarity of two users over their co-rated items.
// ----------------------------------------------------------------------------
// Usage: push one item (both users' ratings, 0 = unrated, plus last_item) per
// transaction while full is low. The front takes one item every cycle unless
// full; the item marked last_item closes the pair and its sums go into a
// two-entry queue, so a new pair can stream in while the back end still works.
// Results come out like a queue: while empty is low the result ports hold
// the oldest result; pop takes it. A held result never blocks the back end
// from finishing the next one up to the output register; beyond that the
// queue fills and full rises.
// Special cases: a pair with fewer than two co-rated items or a flat user
// goes from the front's product stage through the queue to the back end's
// done state and skips the multiplier. A computed result takes the shift-add
// multiplier for the variance product, the squared cross sum and fifteen
// search steps, each a multiply by an odd square.
// Reset clears all sums, the queue and the output; both means return to 3.0.
// Means are written over the APB port at byte addresses 0 and 4.
// ----------------------------------------------------------------------------
`default_nettype none

module pearson_corated_similarity (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire pcs_pkg::item_t       item,
    output logic                      empty,
    input  wire logic                 pop,
    output pcs_pkg::result_t          result,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    logic [pcs_pkg::MEAN_W-1:0] mean_first_reg;
    logic [pcs_pkg::MEAN_W-1:0] mean_second_reg;
    logic                       cfg_write;
    logic                       accept;
    logic                       busy_last;
    logic                       q_push;
    pcs_pkg::sums_t             q_wdata;
    pcs_pkg::sums_t             q_rdata;
    logic                       q_not_empty;
    logic [pcs_pkg::QCNT_W-1:0] q_count;
    logic                       q_pop;
    logic                       res_valid;

    // configuration: register index from the word address
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_first_reg  <= pcs_pkg::MEAN_RESET;
            mean_second_reg <= pcs_pkg::MEAN_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2])
                mean_second_reg <= pwdata[pcs_pkg::MEAN_W-1:0];
            else
                mean_first_reg <= pwdata[pcs_pkg::MEAN_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2])
            prdata[pcs_pkg::MEAN_W-1:0] = mean_second_reg;
        else
            prdata[pcs_pkg::MEAN_W-1:0] = mean_first_reg;
    end

    // hold off input when the queue plus a closing item in flight is full
    assign full   = ({1'b0, q_count} + {{pcs_pkg::QCNT_W{1'b0}}, busy_last})
                    >= (pcs_pkg::QCNT_W+1)'(pcs_pkg::QDEPTH);
    assign accept = push & ~full;

    pcs_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .item        (item),
        .mean_first  (mean_first_reg),
        .mean_second (mean_second_reg),
        .q_count     (q_count),
        .busy_last   (busy_last),
        .q_push      (q_push),
        .q_data      (q_wdata)
    );

    pcs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .wdata     (q_wdata),
        .pop       (q_pop),
        .rdata     (q_rdata),
        .not_empty (q_not_empty),
        .count     (q_count)
    );

    pcs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_valid (q_not_empty),
        .rec       (q_rdata),
        .rec_pop   (q_pop),
        .result    (result),
        .res_valid (res_valid),
        .res_pop   (pop)
    );

    assign empty = ~res_valid;

endmodule

`default_nettype wire

/* test/pearson_corated_similarity_test.sv */
// ----------------------------------------------------------------------------
// pearson_corated_similarity_test
// Self-checking bench for the co-rated Pearson similarity block.
// ----------------------------------------------------------------------------
// Streams pairs of rating sequences through the item queue and predicts each
// result with an independent model of the sums, the count and the Q1.14
// square-root search. Means are rewritten over APB between phases, with the
// extremes included. Both queue sides idle at random, with a stretch with no
// idling. One long pair drives the count and the sums into saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module pearson_corated_similarity_test;

    import pcs_pkg::*;

    localparam logic [2:0] ADDR_MEAN_FIRST  = 3'd0;
    localparam logic [2:0] ADDR_MEAN_SECOND = 3'd4;
    localparam int         DRAIN_CYCLES     = 700;   // margin for the back end to settle
    localparam int         STALL_LIMIT      = 5000;  // cycles with no transaction
    localparam int         IDLE_PCT         = 22;

    // Predictor of the block plus the store of expected results.
    class similarity_scoreboard;
        logic [MEAN_W-1:0]         mean_first;
        logic [MEAN_W-1:0]         mean_second;
        logic signed [CROSS_W-1:0] cross_sum;
        logic [SQ_W-1:0]           first_sq;
        logic [SQ_W-1:0]           second_sq;
        logic [CNT_W-1:0]          corated;
        result_t                   pending[$];
        int                        mismatches;

        function new();
            mean_first  = MEAN_RESET;
            mean_second = MEAN_RESET;
            mismatches  = 0;
            clear_sums();
        endfunction

        function void clear_sums();
            cross_sum = '0;
            first_sq  = '0;
            second_sq = '0;
            corated   = '0;
        endfunction

        // Largest m <= 16384 with (2m-1)^2 * a * b <= (|num| * 2^15)^2,
        // which is |num| * 16384 / sqrt(a*b) rounded half away from zero.
        function int unsigned corr_mag(logic [63:0] mag, logic [63:0] a, logic [63:0] b);
            logic [127:0] num2;
            logic [127:0] prod;
            logic [127:0] scaled;
            int unsigned  lo;
            int unsigned  hi;
            int unsigned  mid;
            int unsigned  odd;
            num2 = {64'd0, mag << 15} * {64'd0, mag << 15};
            prod = {64'd0, a} * {64'd0, b};
            lo = 0;
            hi = 16384;
            while (lo < hi) begin
                mid = (lo + hi + 1) / 2;
                odd = 2 * mid - 1;
                scaled = prod * {96'd0, odd * odd};
                if (scaled <= num2)
                    lo = mid;
                else
                    hi = mid - 1;
            end
            return lo;
        endfunction

        function void note_item(item_t it);
            longint    du;
            longint    dv;
            longint    c;
            logic [63:0] s;
            longint    cmax;
            logic [63:0] sqmax;
            result_t   r;
            int unsigned m;
            longint    cs;
            cmax  = 64'sh7FFF_FFFF_FFFF;
            sqmax = 64'h7FFF_FFFF_FFFF;
            if (it.rating_first != 0 && it.rating_second != 0) begin
                du = longint'(it.rating_first) * 65536 - longint'(mean_first);
                dv = longint'(it.rating_second) * 65536 - longint'(mean_second);
                c = longint'(cross_sum) + du * dv;
                if (c > cmax) c = cmax;
                if (c < -cmax - 1) c = -cmax - 1;
                cross_sum = c[CROSS_W-1:0];
                s = {17'd0, first_sq} + 64'(du * du);
                first_sq = (s > sqmax) ? sqmax[SQ_W-1:0] : s[SQ_W-1:0];
                s = {17'd0, second_sq} + 64'(dv * dv);
                second_sq = (s > sqmax) ? sqmax[SQ_W-1:0] : s[SQ_W-1:0];
                if (corated < COUNT_CAP)
                    corated = corated + 1'b1;
            end
            if (!it.last_item)
                return;
            r.similarity    = '0;
            r.corated_count = corated;
            if (corated < 2)
                r.status = STATUS_FEW;
            else if (first_sq == 0 || second_sq == 0)
                r.status = STATUS_FLAT;
            else begin
                cs = cross_sum;
                m = corr_mag((cs < 0) ? 64'(-cs) : 64'(cs), 64'(first_sq), 64'(second_sq));
                r.similarity = (cs < 0) ? -SIM_W'(m) : SIM_W'(m);
                r.status     = STATUS_OK;
            end
            pending.push_back(r);
            clear_sums();
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending.size() == 0) begin
                $error("result with nothing expected: sim %0d count %0d status %0d",
                       got.similarity, got.corated_count, got.status);
                mismatches++;
                return;
            end
            want = pending.pop_front();
            if (got.similarity !== want.similarity) begin
                $error("similarity: expected %0d, got %0d", want.similarity, got.similarity);
                mismatches++;
            end
            if (got.corated_count !== want.corated_count) begin
                $error("corated_count: expected %0d, got %0d",
                       want.corated_count, got.corated_count);
                mismatches++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        push     = 1'b0;
    logic        full;
    item_t       item     = '0;
    logic        empty;
    logic        pop      = 1'b0;
    result_t     result;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    similarity_scoreboard sb = new();
    int                   push_idle_pct = IDLE_PCT;
    int                   pop_idle_pct  = IDLE_PCT;
    int                   quiet_cycles  = 0;

    pearson_corated_similarity DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .item    (item),
        .empty   (empty),
        .pop     (pop),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Receiver: idle at random.
    always @(posedge clk)
    begin
        pop <= ($urandom_range(99) >= pop_idle_pct);
    end

    // Monitor at the falling edge: inputs and outputs hold steady until the
    // next rising edge, so what is seen here is what that edge accepts.
    always @(negedge clk)
    begin
        if (rst_n) begin
            if (push && !full)
                sb.note_item(item);
            if (pop && !empty)
                sb.check_result(result);
            if ((push && !full) || (pop && !empty))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Hold one item until a transaction moves it, idling first at random.
    task automatic send_item(input logic [2:0] ru, input logic [2:0] rv,
                             input logic last);
        item_t it;
        it.rating_first  = ru;
        it.rating_second = rv;
        it.last_item     = last;
        while ($urandom_range(99) < push_idle_pct) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        item <= it;
        forever begin
            @(negedge clk);
            if (!full)
                break;
        end
        @(posedge clk);
    endtask

    task automatic stop_push();
        push <= 1'b0;
        @(posedge clk);
    endtask

    // Wait until every expected result is back, then let the back end settle.
    task automatic drain();
        stop_push();
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_mean(input logic [2:0] addr, input logic [MEAN_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {13'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_MEAN_FIRST)
            sb.mean_first = value;
        else
            sb.mean_second = value;
        @(posedge clk);
    endtask

    function automatic logic [2:0] pick_rating();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 12)
            return 3'd0;
        if (roll < 17)
            return 3'($urandom_range(7, 6));
        return 3'($urandom_range(5, 1));
    endfunction

    function automatic logic [MEAN_W-1:0] pick_mean();
        case ($urandom_range(5))
            0: return '0;
            1: return 19'd327680;
            2: return 19'h7FFFF;
            3: return MEAN_RESET;
            default: return MEAN_W'($urandom_range(327680));
        endcase
    endfunction

    // Random pairs of 1..12 items; hold off once mid-phase if asked.
    task automatic random_pairs(input int items, input logic hold_off);
        int sent;
        int len;
        sent = 0;
        while (sent < items) begin
            len = $urandom_range(12, 1);
            for (int k = 0; k < len; k++)
                send_item(pick_rating(), pick_rating(), k == len - 1);
            sent += len;
            if (hold_off && sent >= items / 2) begin
                hold_off = 1'b0;
                stop_push();
                while (sb.pending.size() != 0)
                    @(negedge clk);
            end
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: single item, perfect positive and negative, flat user,
        // unrated items, ratings 6 and 7, an empty pair.
        send_item(3'd5, 3'd5, 1'b1);
        send_item(3'd1, 3'd1, 1'b0);
        send_item(3'd5, 3'd5, 1'b1);
        send_item(3'd1, 3'd5, 1'b0);
        send_item(3'd5, 3'd1, 1'b1);
        send_item(3'd3, 3'd2, 1'b0);
        send_item(3'd3, 3'd4, 1'b1);
        send_item(3'd2, 3'd3, 1'b0);
        send_item(3'd4, 3'd3, 1'b1);
        send_item(3'd0, 3'd4, 1'b0);
        send_item(3'd2, 3'd0, 1'b0);
        send_item(3'd0, 3'd0, 1'b1);
        send_item(3'd7, 3'd6, 1'b0);
        send_item(3'd6, 3'd7, 1'b0);
        send_item(3'd1, 3'd2, 1'b0);
        send_item(3'd0, 3'd7, 1'b1);
        send_item(3'd2, 3'd4, 1'b0);
        send_item(3'd4, 3'd1, 1'b0);
        send_item(3'd5, 3'd3, 1'b1);
        drain();

        // Long pair at extreme means: count and all sums saturate,
        // cross sum toward its negative limit.
        write_mean(ADDR_MEAN_FIRST, '0);
        write_mean(ADDR_MEAN_SECOND, 19'h7FFFF);
        for (int k = 0; k < 1100; k++)
            send_item(3'd7, (k % 2) ? 3'd1 : 3'd2, k == 1099);
        drain();

        // Random phases under new means; the second runs with no idling.
        for (int phase = 0; phase < 5; phase++) begin
            write_mean(ADDR_MEAN_FIRST, pick_mean());
            write_mean(ADDR_MEAN_SECOND, pick_mean());
            push_idle_pct = (phase == 1) ? 0 : IDLE_PCT;
            pop_idle_pct  = (phase == 1) ? 0 : IDLE_PCT;
            random_pairs(160, phase == 2);
            drain();
        end

        if (sb.pending.size() != 0 || sb.mismatches != 0)
            $display("Test completed with failures");
        else
            $display("Test completed successfully");
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
design/pcs_pkg.sv
design/pcs_front.sv
design/pcs_queue.sv
design/pcs_back.sv
design/pearson_corated_similarity.sv
test/pearson_corated_similarity_test.sv
